>>> design/mtp_pkg.sv
// Package for the MT19937 generator: constants, operation codes, state types.
// Used by every module in the design folder.
package mtp_pkg;

  localparam int StateDepth  = 624;
  localparam int ShiftOffset = 397;
  localparam int IndexWidth  = 10;

  localparam logic [31:0] MatrixA   = 32'h9908b0df;
  localparam logic [31:0] HiBit     = 32'h80000000;
  localparam logic [31:0] LoBits    = 32'h7fffffff;
  localparam logic [31:0] SeedMult  = 32'd1812433253;
  localparam logic [31:0] TemperB   = 32'h9d2c5680;
  localparam logic [31:0] TemperC   = 32'hefc60000;
  localparam logic [31:0] SeedReset = 32'd5489;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_RAW    = 2'd1,
    OP_RANGE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED_MUL,
    S_SEED_WR,
    S_TW_RD0,
    S_TW_RD1,
    S_TW_RD2,
    S_TW_WR,
    S_DRAW_RD,
    S_DRAW_TMP,
    S_MOD,
    S_OUT
  } state_t;

  // Output tempering of one state word.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // One step of the twist recurrence.
  function automatic logic [31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] far);
    logic [31:0] y;
    y = (a & HiBit) | (b & LoBits);
    return far ^ (y >> 1) ^ (y[0] ? MatrixA : 32'd0);
  endfunction

endpackage

>>> design/mtp_if.sv
// Valid/ready channel interfaces for input items, results and the seed write.
// Depends on nothing.
interface mtp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  modport source (output valid, operation, range_low, range_high, input ready);
  modport sink   (input valid, operation, range_low, range_high, output ready);
endinterface

interface mtp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface mtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed_value;
  modport source (output valid, seed_value, input ready);
  modport sink   (input valid, seed_value, output ready);
endinterface

>>> design/mersenne_twister_prng_core.sv
// MT19937 generator top level. A ranged draw adds a serial remainder; a draw that
// exhausts the state first twists the whole state word by word; the first draw while
// unseeded also seeds it; equal bounds or an unused op give a result without a draw.
// The next item is accepted in the cycle after each result is loaded; a stalled
// result holds the next item in its last step. One single-port state memory holds
// the state. Reset (rst high) marks the state unseeded, seed 5489.
module mersenne_twister_prng_core
  import mtp_pkg::*;
#(
  parameter int DEPTH = StateDepth,
  parameter int SHIFT = ShiftOffset
) (
  input logic        clk,
  input logic        rst,
  mtp_req_if.sink    req,
  mtp_rsp_if.source  rsp,
  mtp_cfg_if.sink    cfg
);
  logic [31:0] seed_reg;
  logic        req_ready;

  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;

  // Seed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_reg <= SeedReset;
    end else if (cfg.valid) begin
      seed_reg <= cfg.seed_value;
    end
  end

  mtp_ctrl #(.DEPTH(DEPTH), .SHIFT(SHIFT)) u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req_ready), .req_op(req.operation),
    .req_low(req.range_low), .req_high(req.range_high), .seed(seed_reg),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_value(rsp.value)
  );
endmodule

>>> design/mtp_state_ram.sv
// Single-port synchronous state memory with a registered read.
// Uses mtp_pkg for its default depth.
module mtp_state_ram
  import mtp_pkg::*;
#(
  parameter int DEPTH = StateDepth
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [31:0]              wdata,
  output logic [31:0]              rdata
);
  logic [31:0] mem [DEPTH];

  // Write or read one word per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/mtp_mod_unit.sv
// Bit-serial unsigned 32-bit remainder, one quotient bit per cycle.
// Uses mtp_pkg only by convention of the project.
module mtp_mod_unit
  import mtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], quo[31]};
  assign diff    = shifted - {1'b0, dvs};
  assign remainder = rem[31:0];

  // Restoring division loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd32;
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        quo <= {quo[30:0], 1'b0};
        rem <= diff[32] ? shifted : diff;
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> design/mtp_ctrl.sv
// Sequencer: seeding sweep, whole-state twist sweep, draw and range handling.
// Uses mtp_pkg, mtp_state_ram and mtp_mod_unit.
module mtp_ctrl
  import mtp_pkg::*;
#(
  parameter int DEPTH = StateDepth,
  parameter int SHIFT = ShiftOffset
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  req_op,
  input  logic [31:0] req_low,
  input  logic [31:0] req_high,
  input  logic [31:0] seed,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] rsp_value
);
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(DEPTH + 2);
  localparam logic [IW-1:0] IdxFull    = IW'(DEPTH);
  localparam logic [IW-1:0] IdxUnseed  = IW'(DEPTH + 1);
  localparam logic [AW-1:0] LastAddr   = AW'(DEPTH - 1);

  state_t state, state_next;
  logic [IW-1:0] rd_index;
  logic [AW-1:0] k;
  logic [31:0] prev, wa, wb, mulv;
  logic [31:0] lo, span, out_word;
  logic        is_range, after_seed;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;
  logic        mod_start, mod_done;
  logic [31:0] mod_rem;
  logic [31:0] pmix;
  logic [31:0] draw_word;
  logic        out_fire;
  logic [AW-1:0] k_next_addr, k_far_addr;

  mtp_state_ram #(.DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  mtp_mod_unit u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(draw_word), .divisor(span),
    .done(mod_done), .remainder(mod_rem)
  );

  assign pmix        = prev ^ (prev >> 30);
  assign draw_word   = temper(ram_rdata);
  assign k_next_addr = (k == LastAddr) ? '0 : k + AW'(1);
  assign k_far_addr  = (k >= AW'(DEPTH - SHIFT)) ? k - AW'(DEPTH - SHIFT)
                                                : k + AW'(SHIFT);
  assign req_ready   = (state == S_IDLE);
  // The result register takes a new word once the previous one has left.
  assign out_fire    = (state == S_OUT) && (!rsp_valid || rsp_ready);

  // Memory port selection, remainder start and next state per sequencer step.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = k;
    ram_wdata = prev;
    mod_start = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          if (req_op == OP_RESEED) begin
            state_next = S_SEED_WR;
          end else if (req_op == OP_RAW ||
                       (req_op == OP_RANGE && req_low != req_high)) begin
            if (rd_index == IdxUnseed) state_next = S_SEED_WR;
            else if (rd_index == IdxFull) state_next = S_TW_RD0;
            else state_next = S_DRAW_RD;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_SEED_WR: begin
        ram_we = 1'b1;
        ram_wdata = prev;
        state_next = (k == LastAddr) ? (after_seed ? S_OUT : S_TW_RD0) : S_SEED_MUL;
      end
      S_SEED_MUL: state_next = S_SEED_WR;
      S_TW_RD0: begin
        ram_addr = k;
        state_next = S_TW_RD1;
      end
      S_TW_RD1: begin
        ram_addr = k_next_addr;
        state_next = S_TW_RD2;
      end
      S_TW_RD2: begin
        ram_addr = k_far_addr;
        state_next = S_TW_WR;
      end
      S_TW_WR: begin
        ram_we = 1'b1;
        ram_addr = k;
        ram_wdata = mix(wa, wb, ram_rdata);
        state_next = (k == LastAddr) ? S_DRAW_RD : S_TW_RD0;
      end
      S_DRAW_RD: begin
        ram_addr = rd_index[AW-1:0];
        state_next = S_DRAW_TMP;
      end
      S_DRAW_TMP: begin
        state_next = is_range ? S_MOD : S_OUT;
        mod_start = is_range;
      end
      S_MOD: if (mod_done) state_next = S_OUT;
      S_OUT: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_index <= IdxUnseed;
      rsp_valid <= 1'b0;
      k <= '0;
    end else begin
      state <= state_next;
      // Result register: load on a finished item, clear when taken.
      if (out_fire) begin
        rsp_valid <= 1'b1;
        rsp_value <= out_word;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          k <= '0;
          prev <= seed;
          out_word <= '0;
          is_range <= (req_op == OP_RANGE);
          after_seed <= (req_op == OP_RESEED);
          if ($signed(req_low) > $signed(req_high)) begin
            lo <= req_high;
            span <= req_low - req_high;
          end else begin
            lo <= req_low;
            span <= req_high - req_low;
          end
          if (req_op == OP_RANGE) out_word <= req_low;
        end
        S_SEED_WR: begin
          mulv <= SeedMult * pmix;
          if (k == LastAddr) begin
            k <= '0;
            rd_index <= IdxFull;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_SEED_MUL: prev <= mulv + 32'(k);
        S_TW_RD1: wa <= ram_rdata;
        S_TW_RD2: wb <= ram_rdata;
        S_TW_WR: begin
          if (k == LastAddr) begin
            k <= '0;
            rd_index <= '0;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_DRAW_TMP: begin
          out_word <= draw_word;
          rd_index <= rd_index + IW'(1);
        end
        S_MOD: if (mod_done) out_word <= lo + mod_rem;
        default: ;
      endcase
    end
  end
endmodule
